>>> rtl/tlsr_pkg.sv
// ----------------------------------------------------------------------------
// Thick line stamp rasterizer package
// Shared constants, operation codes and bus widths of the line stamp block.
// ----------------------------------------------------------------------------
package tlsr_pkg;

	localparam int SURFACE_WIDTH  = 96;
	localparam int SURFACE_HEIGHT = 64;

	localparam int COORD_W   = 8;
	localparam int POS_W     = 7;
	localparam int SIZE_W    = 4;
	localparam int S_TDATA_W = 4 * COORD_W;
	localparam int M_TDATA_W = 24;

	localparam logic [SIZE_W-1:0] THICK_RESET = 4'd3;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_STEP = 1'b1
	} op_t;

endpackage

>>> rtl/thick_line_stamp_rasterizer_top.sv
// ----------------------------------------------------------------------------
// Thick line stamp rasterizer
// Walks a line with the Bresenham algorithm and returns, for each step
// transaction taken during a walk, the square brush stamp at the current
// point clipped to the display surface.
// ----------------------------------------------------------------------------
// A step transaction taken during a walk shows its stamp on the master side in
// the cycle after it is accepted; a load, or a step outside a walk, gives none.
// Throughput: one transaction per cycle while the master side does not stall,
// set by the single registered Bresenham update and the output register.
// Reset: arst_n clears the walk state, empties the output register and sets
// the brush thickness to three pixels.
module thick_line_stamp_rasterizer_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tlsr_pkg::SIZE_W-1:0]   cfg_wdata,    // brush_thickness
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tlsr_pkg::S_TDATA_W-1:0] s_tdata,     // start_x, start_y, end_x, end_y
	input  logic                          s_tuser,      // operation
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tlsr_pkg::M_TDATA_W-1:0] m_tdata,     // rect_x, rect_y, rect_w, rect_h, pad
	output logic                          m_tuser,      // visible
	output logic                          m_tlast       // last
);
	import tlsr_pkg::*;

	typedef struct packed {
		logic [POS_W-1:0]  lo;
		logic [SIZE_W-1:0] len;
		logic              ok;
	} clip_t;

	localparam logic signed [9:0] SURF_W_S = 10'(SURFACE_WIDTH);
	localparam logic signed [9:0] SURF_H_S = 10'(SURFACE_HEIGHT);

	function automatic clip_t clip_axis(input logic [COORD_W-1:0] pos,
			input logic [SIZE_W-1:0] thick, input logic signed [9:0] limit);
		logic signed [9:0] lo;
		logic signed [9:0] len;
		clip_t             res;
		lo  = $signed({{2{pos[COORD_W-1]}}, pos} - {7'b0, thick[SIZE_W-1:1]});
		len = $signed({6'b0, thick});
		if (lo < 10'sd0) begin
			len = len + lo;
			lo  = 10'sd0;
		end
		if (lo + len > limit) begin
			len = limit - lo;
		end
		res.lo  = lo[POS_W-1:0];
		res.len = len[SIZE_W-1:0];
		res.ok  = (len > 10'sd0);
		return res;
	endfunction

	logic [SIZE_W-1:0]          thick_q;
	logic signed [COORD_W-1:0]  cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [8:0]                 dx_q;
	logic signed [9:0]          ndy_q;
	logic                       sxn_q, syn_q;
	logic signed [10:0]         err_q;
	logic                       walking_q;

	logic                       out_valid_q;
	logic [M_TDATA_W-1:0]       out_data_q;
	logic                       out_vis_q;
	logic                       out_last_q;

	logic signed [COORD_W-1:0]  in_sx, in_sy, in_ex, in_ey;
	logic signed [8:0]          diff_x, diff_y;
	logic [8:0]                 mag_x, mag_y;
	logic                       accept, do_load, do_step;
	logic                       at_end;
	logic signed [11:0]         e2;
	logic                       move_x, move_y;
	logic signed [11:0]         err_next;
	clip_t                      clip_x, clip_y;
	logic                       vis;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign do_load  = accept && (op_t'(s_tuser) == OP_LOAD);
	assign do_step  = accept && (op_t'(s_tuser) == OP_STEP) && walking_q;

	assign in_sx = s_tdata[7:0];
	assign in_sy = s_tdata[15:8];
	assign in_ex = s_tdata[23:16];
	assign in_ey = s_tdata[31:24];

	always_comb begin
		diff_x = 9'(in_ex) - 9'(in_sx);
		diff_y = 9'(in_ey) - 9'(in_sy);
		mag_x  = diff_x[8] ? 9'(-diff_x) : diff_x;
		mag_y  = diff_y[8] ? 9'(-diff_y) : diff_y;
	end

	always_comb begin
		at_end   = (cur_x_q == tgt_x_q) && (cur_y_q == tgt_y_q);
		e2       = {err_q, 1'b0};
		move_x   = (e2 >= 12'(ndy_q));
		move_y   = (e2 <= $signed({3'b0, dx_q}));
		err_next = 12'(err_q);
		if (move_x) begin
			err_next = err_next + 12'(ndy_q);
		end
		if (move_y) begin
			err_next = err_next + $signed({3'b0, dx_q});
		end
		clip_x = clip_axis(cur_x_q, thick_q, SURF_W_S);
		clip_y = clip_axis(cur_y_q, thick_q, SURF_H_S);
		vis    = clip_x.ok && clip_y.ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thick_q <= THICK_RESET;
		end else if (cfg_we) begin
			thick_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			tgt_x_q   <= '0;
			tgt_y_q   <= '0;
			dx_q      <= '0;
			ndy_q     <= '0;
			sxn_q     <= 1'b0;
			syn_q     <= 1'b0;
			err_q     <= '0;
			walking_q <= 1'b0;
		end else if (do_load) begin
			cur_x_q   <= in_sx;
			cur_y_q   <= in_sy;
			tgt_x_q   <= in_ex;
			tgt_y_q   <= in_ey;
			dx_q      <= mag_x;
			ndy_q     <= -$signed({1'b0, mag_y});
			sxn_q     <= !(in_sx < in_ex);
			syn_q     <= !(in_sy < in_ey);
			err_q     <= $signed({2'b0, mag_x}) - $signed({2'b0, mag_y});
			walking_q <= 1'b1;
		end else if (do_step) begin
			if (at_end) begin
				walking_q <= 1'b0;
			end else begin
				err_q <= err_next[10:0];
				if (move_x) begin
					cur_x_q <= sxn_q ? cur_x_q - 8'sd1 : cur_x_q + 8'sd1;
				end
				if (move_y) begin
					cur_y_q <= syn_q ? cur_y_q - 8'sd1 : cur_y_q + 8'sd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			if (vis) begin
				out_data_q <= {2'b0, clip_y.len, clip_x.len, clip_y.lo, clip_x.lo};
			end else begin
				out_data_q <= '0;
			end
			out_vis_q  <= vis;
			out_last_q <= at_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_vis_q;
	assign m_tlast  = out_last_q;

endmodule

>>> rtl/tlsr_checker.sv
// ----------------------------------------------------------------------------
// Thick line stamp rasterizer port checker
// Watches the ports of the top level and flags stamps or handshakes that the
// block must never show.
// ----------------------------------------------------------------------------
module tlsr_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [tlsr_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                           m_tuser,
	input logic                           m_tlast
);
	import tlsr_pkg::*;

	// A stamp that is held back must not change.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled stamp changed");

	// An invisible stamp carries an empty rectangle.
	a_invisible: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("invisible stamp with non-zero rectangle");

	// A visible stamp has a non-empty rectangle whose corner lies on the surface.
	a_visible: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[17:14] != 4'd0 && m_tdata[21:18] != 4'd0
			&& m_tdata[6:0] < 7'(SURFACE_WIDTH) && m_tdata[13:7] < 7'(SURFACE_HEIGHT))
		else $error("visible stamp with empty or off-surface rectangle");

	// No new transaction is taken while a stamp waits on a stalled output.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input ready while the output register is full");

endmodule

bind thick_line_stamp_rasterizer_top tlsr_checker u_tlsr_checker (.*);
